// File: rtl/wrench_moving_average_core_defines.svh
// Assertion macros shared by the moving average RTL.
`ifndef WRENCH_MOVING_AVERAGE_CORE_DEFINES_SVH
`define WRENCH_MOVING_AVERAGE_CORE_DEFINES_SVH

// Checked property, disabled while the reset is asserted.
`define WMA_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked property that also holds through reset.
`define WMA_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: rtl/wma_pkg.sv
// Shared types and constants for the wrench moving average block.
package wma_pkg;

  localparam int DATA_W         = 24;
  localparam int CHANNELS       = 6;
  localparam int WINDOW_DEFAULT = 8;
  // Quotient bits produced per cycle by the divider.
  localparam int DIV_STEPS      = 4;

  typedef logic signed [DATA_W-1:0] chan_t;
  typedef chan_t [CHANNELS-1:0] wrench_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACCUM,
    ST_SETUP,
    ST_DIVIDE,
    ST_FINISH
  } state_t;

endpackage

// File: rtl/wma_in_if.sv
// Input channel carrying one six-axis force/torque sample per transaction.
interface wma_in_if;
  logic                             valid;
  logic                             ready;
  logic signed [wma_pkg::DATA_W-1:0] force_x_in;
  logic signed [wma_pkg::DATA_W-1:0] force_y_in;
  logic signed [wma_pkg::DATA_W-1:0] force_z_in;
  logic signed [wma_pkg::DATA_W-1:0] torque_x_in;
  logic signed [wma_pkg::DATA_W-1:0] torque_y_in;
  logic signed [wma_pkg::DATA_W-1:0] torque_z_in;

  modport source (
    output valid, force_x_in, force_y_in, force_z_in,
    output torque_x_in, torque_y_in, torque_z_in,
    input  ready
  );

  modport sink (
    input  valid, force_x_in, force_y_in, force_z_in,
    input  torque_x_in, torque_y_in, torque_z_in,
    output ready
  );
endinterface

// File: rtl/wma_out_if.sv
// Output channel carrying one six-axis averaged result per transaction.
interface wma_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [wma_pkg::DATA_W-1:0] force_x_avg;
  logic signed [wma_pkg::DATA_W-1:0] force_y_avg;
  logic signed [wma_pkg::DATA_W-1:0] force_z_avg;
  logic signed [wma_pkg::DATA_W-1:0] torque_x_avg;
  logic signed [wma_pkg::DATA_W-1:0] torque_y_avg;
  logic signed [wma_pkg::DATA_W-1:0] torque_z_avg;

  modport source (
    output valid, force_x_avg, force_y_avg, force_z_avg,
    output torque_x_avg, torque_y_avg, torque_z_avg,
    input  ready
  );

  modport sink (
    input  valid, force_x_avg, force_y_avg, force_z_avg,
    input  torque_x_avg, torque_y_avg, torque_z_avg,
    output ready
  );
endinterface

// File: rtl/wrench_moving_average_core.sv
// Six-channel boxcar moving average over a ring memory of the last WINDOW samples.
// Each accepted sample is registered, added to the running sums, and then divided by the
// fill count in six shared-step restoring dividers that retire four quotient bits per
// cycle; a new sample is taken only once the last result has been loaded for output.
// A waiting result sits in the output register while the next sample is processed.
// Reset (synchronous) clears position, fill count, running sums and control; the
// ring memory is not cleared and no clearing pass is needed.
`include "wrench_moving_average_core_defines.svh"

module wrench_moving_average_core #(
  parameter int WINDOW = wma_pkg::WINDOW_DEFAULT
) (
  input  logic      clk,
  input  logic      rst,
  wma_in_if.sink    samples,
  wma_out_if.source averages
);

  localparam int DW        = wma_pkg::DATA_W;
  localparam int CH        = wma_pkg::CHANNELS;
  localparam int STEPS     = wma_pkg::DIV_STEPS;
  localparam int POS_W     = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CNT_W     = $clog2(WINDOW + 1);
  localparam int SUM_W     = DW + $clog2(WINDOW);
  localparam int DIV_ITERS = (SUM_W + STEPS - 1) / STEPS;
  localparam int DVD_W     = DIV_ITERS * STEPS;
  localparam int ITER_W    = (DIV_ITERS > 1) ? $clog2(DIV_ITERS) : 1;

  localparam logic [POS_W-1:0]  LAST_POS  = POS_W'(WINDOW - 1);
  localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(WINDOW);
  localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(DIV_ITERS - 1);

  wma_pkg::state_t  state, state_next;
  wma_pkg::wrench_t ring [WINDOW];
  wma_pkg::wrench_t sample;
  wma_pkg::wrench_t old_entry;
  wma_pkg::wrench_t result;

  logic [POS_W-1:0]        wr_pos;
  logic [CNT_W-1:0]        fill_count;
  logic signed [SUM_W-1:0] sums [CH];
  logic [CH-1:0]           neg;
  logic [DVD_W-1:0]        dvd [CH];
  logic [DVD_W-1:0]        dvd_next [CH];
  logic [CNT_W-1:0]        rem [CH];
  logic [CNT_W-1:0]        rem_next [CH];
  logic [ITER_W-1:0]       iter;
  logic                    out_valid;
  logic                    accept;
  logic                    load_out;
  logic                    full;

  assign accept = samples.valid && samples.ready;
  assign full   = (fill_count == FULL_CNT);

  // Control state machine.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= wma_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    samples.ready = 1'b0;
    load_out      = 1'b0;
    case (state)
      wma_pkg::ST_IDLE: begin
        samples.ready = 1'b1;
        if (samples.valid) begin
          state_next = wma_pkg::ST_ACCUM;
        end
      end
      wma_pkg::ST_ACCUM: begin
        state_next = wma_pkg::ST_SETUP;
      end
      wma_pkg::ST_SETUP: begin
        state_next = wma_pkg::ST_DIVIDE;
      end
      wma_pkg::ST_DIVIDE: begin
        if (iter == '0) begin
          state_next = wma_pkg::ST_FINISH;
        end
      end
      wma_pkg::ST_FINISH: begin
        if (!out_valid || averages.ready) begin
          load_out   = 1'b1;
          state_next = wma_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = wma_pkg::ST_IDLE;
      end
    endcase
  end

  // Ring memory: the slot about to be overwritten is read when the transaction is
  // taken, and the new sample is written back in the following cycle.
  always_ff @(posedge clk) begin
    if (accept) begin
      old_entry <= ring[wr_pos];
    end
    if (state == wma_pkg::ST_ACCUM) begin
      ring[wr_pos] <= sample;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sample[0] <= samples.force_x_in;
      sample[1] <= samples.force_y_in;
      sample[2] <= samples.force_z_in;
      sample[3] <= samples.torque_x_in;
      sample[4] <= samples.torque_y_in;
      sample[5] <= samples.torque_z_in;
    end
  end

  // Running sums over the filled slots. Once the ring is full the overwritten
  // sample leaves the window; before that the slot was never written.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_pos     <= '0;
      fill_count <= '0;
      for (int c = 0; c < CH; c++) begin
        sums[c] <= '0;
      end
    end else if (state == wma_pkg::ST_ACCUM) begin
      wr_pos <= (wr_pos == LAST_POS) ? '0 : wr_pos + POS_W'(1);
      if (!full) begin
        fill_count <= fill_count + CNT_W'(1);
      end
      for (int c = 0; c < CH; c++) begin
        sums[c] <= sums[c] + SUM_W'($signed(sample[c]))
                 - (full ? SUM_W'($signed(old_entry[c])) : SUM_W'(0));
      end
    end
  end

  // Restoring divide of each magnitude by the fill count, STEPS bits per cycle.
  always_comb begin
    logic [CNT_W:0]   t;
    logic [CNT_W-1:0] r;
    logic [DVD_W-1:0] d;
    logic             qbit;
    for (int c = 0; c < CH; c++) begin
      r = rem[c];
      d = dvd[c];
      for (int s = 0; s < STEPS; s++) begin
        t = {r, d[DVD_W-1]};
        if (t >= {1'b0, fill_count}) begin
          r    = CNT_W'(t - {1'b0, fill_count});
          qbit = 1'b1;
        end else begin
          r    = t[CNT_W-1:0];
          qbit = 1'b0;
        end
        d = {d[DVD_W-2:0], qbit};
      end
      rem_next[c] = r;
      dvd_next[c] = d;
    end
  end

  always_ff @(posedge clk) begin
    if (state == wma_pkg::ST_SETUP) begin
      iter <= ITER_LAST;
      for (int c = 0; c < CH; c++) begin
        neg[c] <= sums[c][SUM_W-1];
        rem[c] <= '0;
        dvd[c] <= DVD_W'(sums[c][SUM_W-1] ? unsigned'(-sums[c]) : unsigned'(sums[c]));
      end
    end else if (state == wma_pkg::ST_DIVIDE) begin
      iter <= iter - ITER_W'(1);
      for (int c = 0; c < CH; c++) begin
        rem[c] <= rem_next[c];
        dvd[c] <= dvd_next[c];
      end
    end
  end

  // Output register; the quotient magnitude always fits the field width.
  always_ff @(posedge clk) begin
    if (load_out) begin
      for (int c = 0; c < CH; c++) begin
        result[c] <= neg[c] ? -dvd[c][DW-1:0] : dvd[c][DW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (averages.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign averages.valid        = out_valid;
  assign averages.force_x_avg  = result[0];
  assign averages.force_y_avg  = result[1];
  assign averages.force_z_avg  = result[2];
  assign averages.torque_x_avg = result[3];
  assign averages.torque_y_avg = result[4];
  assign averages.torque_z_avg = result[5];

  `WMA_ASSERT(a_accept_starts_update, clk, rst,
    accept |=> (state == wma_pkg::ST_ACCUM), "accepted sample did not start an update")
  `WMA_ASSERT(a_rem_below_divisor, clk, rst,
    (state == wma_pkg::ST_DIVIDE) |-> (rem[0] < fill_count && fill_count != '0),
    "divider remainder not below the fill count")
  `WMA_ASSERT(a_result_from_finish, clk, rst,
    $rose(out_valid) |-> ($past(state) == wma_pkg::ST_FINISH),
    "result appeared without a finished division")
  `WMA_ASSERT(a_fill_moves_on_update, clk, rst,
    ($past(state) != wma_pkg::ST_ACCUM) |-> $stable(fill_count),
    "fill count changed outside an update")
  `WMA_ASSERT_ALWAYS(a_fill_bounded, clk,
    rst || (fill_count <= FULL_CNT), "fill count beyond the window")

endmodule
